// File: design/pfru_pkg.sv
// Package for the page frame replacement unit.
// Holds the sequencer state type, policy and register codes, and the field widths.
// No dependencies.
`default_nettype none

package pfru_pkg;

   // Field widths on the stream ports
   localparam int PAGE_W   = 8;    // page_number, evicted_page
   localparam int SLOT_W   = 3;    // frame_slot
   localparam int FAULT_W  = 16;   // fault_count
   localparam int REQ_W    = 8;    // req_tdata
   localparam int RSP_W    = 32;   // rsp_tdata: slot + evicted + count, padded to bytes
   localparam int RSP_U_W  = 2;    // rsp_tuser: was_hit, was_replacement

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES = 1'b1;

   // Replacement policy codes
   localparam logic [1:0] POLICY_FIFO  = 2'd0;
   localparam logic [1:0] POLICY_CLOCK = 2'd1;
   localparam logic [1:0] POLICY_LRU   = 2'd2;

   localparam logic [3:0] FRAMES_RESET = 4'd3;
   localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

   // Sequencer states
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_LRU   = 7'b0000100,
      S_CLK   = 7'b0001000,
      S_EVRD  = 7'b0010000,
      S_EVCAP = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// File: design/pfru_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the resident page table. No dependencies.
`default_nettype none

module pfru_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: design/page_frame_replacement_unit.sv
// Page frame replacement unit, top level.
// Depends on pfru_pkg and pfru_ram (resident page table).
//
// Usage
//   req_*  : one page reference per transfer (req_tdata[7:0] = page_number).
//   rsp_*  : one result per reference: tuser = {was_replacement, was_hit},
//            tdata = {pad, fault_count, evicted_page, frame_slot}.
//   csr_*  : register writes, index 0 = policy_mode (0 FIFO, 1 CLOCK, 2 LRU),
//            index 1 = frame_count. csr_ready is always high; write only while idle.
//   Timing: one reference at a time. A single compare path visits one frame per
//   cycle: the lookup walks the resident frames through the page RAM's registered
//   read, an LRU victim search walks the frames in use, a CLOCK sweep clears use
//   bits until a clear one is under the hand, then the evicted page is read and
//   the table update is committed together with the result. The next reference
//   is taken once the block is back in idle after the commit.
//   The result sits in an output register, so a stalled receiver holds the
//   block only when the next result is ready to be written.
//   Reset (synchronous, active high) empties the table, clears use bits,
//   recency, hand and fault count, and sets FIFO with 3 frames.
`default_nettype none

module page_frame_replacement_unit #(
   parameter int MAX_FRAMES = 8,
   parameter int PAGE_BITS  = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [pfru_pkg::REQ_W-1:0]      req_tdata,   // [7:0] page_number
   // result stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [pfru_pkg::RSP_W-1:0]           rsp_tdata,   // [2:0] frame_slot,
                                                             // [10:3] evicted_page,
                                                             // [26:11] fault_count
   output logic [pfru_pkg::RSP_U_W-1:0]         rsp_tuser,   // [0] was_hit,
                                                             // [1] was_replacement
   // register writes
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [pfru_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pfru_pkg::CSR_DATA_W-1:0] csr_data
);

   import pfru_pkg::*;

   localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;  // frame index
   localparam int CW = $clog2(MAX_FRAMES + 1);                      // frame count
   localparam int RW = IW;                                          // recency rank

   // registers
   state_type           state_ff,   state_in;
   logic [1:0]          policy_ff,  policy_in;
   logic [3:0]          fcount_ff,  fcount_in;
   logic [PAGE_BITS-1:0] page_ff,   page_in;
   logic [CW-1:0]       n_ff,       n_in;
   logic [CW-1:0]       act_ff,     act_in;
   logic [1:0]          mode_ff,    mode_in;
   logic [CW-1:0]       scan_ff,    scan_in;
   logic                pend_ff,    pend_in;
   logic [IW-1:0]       pidx_ff,    pidx_in;
   logic [IW-1:0]       cur_ff,     cur_in;
   logic [IW-1:0]       slot_ff,    slot_in;
   logic                hit_ff,     hit_in;
   logic                repl_ff,    repl_in;
   logic                hupd_ff,    hupd_in;
   logic [PAGE_BITS-1:0] evict_ff,  evict_in;
   logic [RW-1:0]       best_ff,    best_in;
   logic [CW-1:0]       tlim_ff,    tlim_in;
   logic                tall_ff,    tall_in;
   logic [IW-1:0]       hand_ff,    hand_in;
   logic [CW-1:0]       filled_ff,  filled_in;
   logic [FAULT_W-1:0]  total_ff,   total_in;
   logic                use_ff  [MAX_FRAMES];
   logic                use_in  [MAX_FRAMES];
   logic [RW-1:0]       rank_ff [MAX_FRAMES];
   logic [RW-1:0]       rank_in [MAX_FRAMES];
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]            rsp_data_ff,  rsp_data_in;
   logic [RSP_U_W-1:0]          rsp_user_ff,  rsp_user_in;

   // combinational helpers
   logic [7:0]          fc_wide;
   logic [CW-1:0]       eff_n;
   logic [1:0]          mode_dec;
   logic                out_free;
   logic [IW-1:0]       cur_next;
   logic [IW-1:0]       rank_rd_idx;
   logic [RW-1:0]       rank_rd;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [IW-1:0]       ram_rd_addr;
   logic [PAGE_BITS-1:0] ram_rd_data;
   logic [FAULT_W-1:0]  total_next;

   // page table
   pfru_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (MAX_FRAMES),
      .ADDR_W(IW)
   ) u_pages (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(slot_ff),
      .wr_data(page_ff),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // effective frame count and policy
   assign fc_wide = 8'(fcount_ff);
   assign eff_n   = (fc_wide == 8'd0) ? CW'(1) :
                    (fc_wide > 8'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(fc_wide);

   always_comb begin
      case (policy_ff)
         POLICY_CLOCK: mode_dec = POLICY_CLOCK;
         POLICY_LRU:   mode_dec = POLICY_LRU;
         default:      mode_dec = POLICY_FIFO;
      endcase
   end

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign cur_next    = ((CW'(cur_ff) + CW'(1)) == n_ff) ? '0 : cur_ff + IW'(1);
   assign rank_rd_idx = (state_ff == S_LRU) ? scan_ff[IW-1:0] : slot_ff;
   assign rank_rd     = rank_ff[rank_rd_idx];
   assign total_next  = (repl_ff && total_ff != FAULT_MAX) ? total_ff + FAULT_W'(1)
                                                            : total_ff;

   // page RAM port control
   assign ram_rd_en   = ((state_ff == S_SCAN) && (scan_ff < act_ff)) || (state_ff == S_EVRD);
   assign ram_rd_addr = (state_ff == S_EVRD) ? slot_ff : scan_ff[IW-1:0];
   assign ram_wr_en   = (state_ff == S_DONE) && out_free && !hit_ff;

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      policy_in = policy_ff;
      fcount_in = fcount_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_POLICY: policy_in = csr_data[1:0];
            CSR_FRAMES: fcount_in = csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      page_in   = page_ff;
      n_in      = n_ff;
      act_in    = act_ff;
      mode_in   = mode_ff;
      scan_in   = scan_ff;
      pend_in   = pend_ff;
      pidx_in   = pidx_ff;
      cur_in    = cur_ff;
      slot_in   = slot_ff;
      hit_in    = hit_ff;
      repl_in   = repl_ff;
      hupd_in   = hupd_ff;
      evict_in  = evict_ff;
      best_in   = best_ff;
      tlim_in   = tlim_ff;
      tall_in   = tall_ff;
      hand_in   = hand_ff;
      filled_in = filled_ff;
      total_in  = total_ff;
      use_in    = use_ff;
      rank_in   = rank_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_tready);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               page_in  = PAGE_BITS'(req_tdata[PAGE_W-1:0]);
               n_in     = eff_n;
               act_in   = (filled_ff < eff_n) ? filled_ff : eff_n;
               cur_in   = (CW'(hand_ff) < eff_n) ? hand_ff : '0;
               mode_in  = mode_dec;
               scan_in  = '0;
               pend_in  = 1'b0;
               state_in = S_SCAN;
            end
         end

         // lookup: one frame compared per cycle behind the RAM read
         S_SCAN: begin
            if (pend_ff && ram_rd_data == page_ff) begin
               slot_in  = pidx_ff;
               hit_in   = 1'b1;
               repl_in  = 1'b0;
               hupd_in  = 1'b0;
               evict_in = '0;
               tlim_in  = act_ff;
               tall_in  = 1'b0;
               state_in = S_DONE;
            end else if (scan_ff < act_ff) begin
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
               pidx_in = scan_ff[IW-1:0];
            end else begin
               pend_in = 1'b0;
               hit_in  = 1'b0;
               if (filled_ff < n_ff) begin
                  // fill the next free frame
                  slot_in  = filled_ff[IW-1:0];
                  repl_in  = 1'b0;
                  hupd_in  = 1'b1;
                  evict_in = '0;
                  tlim_in  = act_ff + CW'(1);
                  tall_in  = 1'b1;
                  state_in = S_DONE;
               end else begin
                  repl_in = 1'b1;
                  tlim_in = n_ff;
                  tall_in = 1'b0;
                  hupd_in = (mode_ff != POLICY_LRU);
                  case (mode_ff)
                     POLICY_LRU: begin
                        scan_in  = CW'(1);
                        slot_in  = '0;
                        best_in  = rank_ff[0];
                        state_in = S_LRU;
                     end
                     POLICY_CLOCK: state_in = S_CLK;
                     default: begin
                        slot_in  = cur_ff;
                        state_in = S_EVRD;
                     end
                  endcase
               end
            end
         end

         // LRU: highest rank wins, lowest index on ties
         S_LRU: begin
            if (scan_ff < n_ff) begin
               if (rank_rd > best_ff) begin
                  best_in = rank_rd;
                  slot_in = scan_ff[IW-1:0];
               end
               scan_in = scan_ff + CW'(1);
            end else begin
               state_in = S_EVRD;
            end
         end

         // CLOCK: clear use bits until a clear one is under the hand
         S_CLK: begin
            if (!use_ff[cur_ff]) begin
               slot_in  = cur_ff;
               state_in = S_EVRD;
            end else begin
               use_in[cur_ff] = 1'b0;
               cur_in = cur_next;
            end
         end

         S_EVRD: state_in = S_EVCAP;

         S_EVCAP: begin
            evict_in = ram_rd_data;
            state_in = S_DONE;
         end

         // commit the table update and post the result
         S_DONE: begin
            if (out_free) begin
               for (int k = 0; k < MAX_FRAMES; k++) begin
                  if (CW'(k) < tlim_ff && IW'(k) != slot_ff &&
                      (tall_ff || rank_ff[k] < rank_rd)) begin
                     rank_in[k] = rank_ff[k] + RW'(1);
                  end
               end
               rank_in[slot_ff] = '0;
               if (!repl_ff) begin
                  use_in[slot_ff] = 1'b1;
               end
               if (!hit_ff && !repl_ff) begin
                  filled_in = filled_ff + CW'(1);
               end
               if (hupd_ff) begin
                  hand_in = cur_next;
               end
               total_in     = total_next;
               rsp_user_in  = {repl_ff, hit_ff};
               rsp_data_in  = RSP_W'({total_next, PAGE_W'(evict_ff), SLOT_W'(slot_ff)});
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         policy_ff    <= POLICY_FIFO;
         fcount_ff    <= FRAMES_RESET;
         hand_ff      <= '0;
         filled_ff    <= '0;
         total_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_FRAMES; k++) begin
            use_ff[k]  <= 1'b0;
            rank_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         fcount_ff    <= fcount_in;
         hand_ff      <= hand_in;
         filled_ff    <= filled_in;
         total_ff     <= total_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         use_ff       <= use_in;
         rank_ff      <= rank_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      n_ff        <= n_in;
      act_ff      <= act_in;
      mode_ff     <= mode_in;
      scan_ff     <= scan_in;
      pidx_ff     <= pidx_in;
      cur_ff      <= cur_in;
      slot_ff     <= slot_in;
      hit_ff      <= hit_in;
      repl_ff     <= repl_in;
      hupd_ff     <= hupd_in;
      evict_ff    <= evict_in;
      best_ff     <= best_in;
      tlim_ff     <= tlim_in;
      tall_ff     <= tall_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CW'(MAX_FRAMES))
      else $error("filled frame count above table depth");

   a_fault_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> total_ff >= $past(total_ff))
      else $error("fault count went down");

   a_commit_posts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && out_free |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("commit did not post a result");

   a_hit_not_repl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_user_ff[0] && rsp_user_ff[1]))
      else $error("result flagged both hit and replacement");

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> (state_ff == S_SCAN) && !pend_ff)
      else $error("accepted reference did not start a lookup");

endmodule

`default_nettype wire

// File: tb/sv/page_frame_replacement_unit_tb.sv
// Self-checking testbench for the page frame replacement unit.
// Drives page references, checks each result against a directed expectation or a built-in predictor.
// Depends on pfru_pkg and the page_frame_replacement_unit RTL.
`default_nettype none

module page_frame_replacement_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfru_pkg::*;

   localparam int unsigned FRAME_DEPTH   = 8;
   localparam int unsigned RANDOM_REFS   = 1680;
   localparam int unsigned LAST_REFS     = 120;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned HOLD_AT       = 400;
   localparam int unsigned DRAIN_CYCLES  = 30;
   localparam int unsigned CYCLE_LIMIT   = 500_000;
   localparam logic [1:0]  POLICY_UNKNOWN = 2'd3;

   // One result: packed in the order hit, replacement, slot, evicted page, fault count
   typedef struct packed {
      logic               hit;
      logic               repl;
      logic [SLOT_W-1:0]  slot;
      logic [PAGE_W-1:0]  evicted;
      logic [FAULT_W-1:0] faults;
   } frame_result_type;

   typedef enum logic [1:0] {ROW_PAGE, ROW_CHECKED, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_IDX_W-1:0]    reg_sel;
      logic [CSR_DATA_W-1:0]   value;
      logic [PAGE_W-1:0]       page;
      frame_result_type        want;
   } plan_row_type;

   localparam int unsigned PLAN_ROWS = 29;

   // Directed walk: fill, hit, FIFO replace, unknown policy, CLOCK sweep,
   // frame count forced low then past the top, LRU with ties, page extremes
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{ROW_CHECKED, CSR_POLICY, 4'd0, 8'h00, '{1'b0, 1'b0, 3'd0, 8'h00, 16'd0}},
      '{ROW_CHECKED, CSR_POLICY, 4'd0, 8'hFF, '{1'b0, 1'b0, 3'd1, 8'h00, 16'd0}},
      '{ROW_CHECKED, CSR_POLICY, 4'd0, 8'h00, '{1'b1, 1'b0, 3'd0, 8'h00, 16'd0}},
      '{ROW_CHECKED, CSR_POLICY, 4'd0, 8'h5A, '{1'b0, 1'b0, 3'd2, 8'h00, 16'd0}},
      '{ROW_CHECKED, CSR_POLICY, 4'd0, 8'hA5, '{1'b0, 1'b1, 3'd0, 8'h00, 16'd1}},
      '{ROW_CSR,     CSR_POLICY, {2'b00, POLICY_UNKNOWN}, 8'h00, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h01, '0},
      '{ROW_CSR,     CSR_POLICY, {2'b00, POLICY_CLOCK}, 8'h00, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h5A, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h33, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'hA5, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'hCC, '0},
      '{ROW_CSR,     CSR_FRAMES, 4'd0, 8'h00, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h33, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h77, '0},
      '{ROW_CSR,     CSR_FRAMES, 4'd15, 8'h00, '0},
      '{ROW_CSR,     CSR_POLICY, {2'b00, POLICY_LRU}, 8'h00, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h10, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h20, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h30, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h40, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h50, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h10, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h80, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h81, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h82, '0},
      '{ROW_CSR,     CSR_FRAMES, 4'd8, 8'h00, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'hFE, '0},
      '{ROW_PAGE,    CSR_POLICY, 4'd0, 8'h7F, '0}
   };

   // Frame counts used by the first random phases, then random
   localparam int unsigned SWEEP_LEN = 5;
   logic [CSR_DATA_W-1:0] frame_sweep [SWEEP_LEN] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2};

   // DUT ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic [RSP_U_W-1:0]     rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   page_frame_replacement_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Predictor state: frame table, use bits, recency, fill level, hand, faults
   logic [PAGE_W-1:0] resident_page [FRAME_DEPTH];
   bit                use_bit       [FRAME_DEPTH];
   int unsigned       rank_of       [FRAME_DEPTH];
   int unsigned       filled_count;
   int unsigned       hand_pos;
   int unsigned       fault_total;
   logic [1:0]        cfg_policy;
   logic [3:0]        cfg_frames;

   frame_result_type  pending_results [$];
   int unsigned       mismatches;
   int unsigned       results_seen;
   int unsigned       references;
   int unsigned       reg_writes;
   int unsigned       cycle_count;
   bit                idle_on;
   bit                hold_done;

   // Clock
   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Move frame f to most recent; frames more recent than it age by one
   function automatic void touch_frame(input int unsigned f, input int unsigned act,
                                       input int unsigned old_rank);
      for (int unsigned k = 0; k < act; k++) begin
         if (k != f && rank_of[k] < old_rank && rank_of[k] < 255) begin
            rank_of[k]++;
         end
      end
      rank_of[f] = 0;
   endfunction

   // Look up one page reference and update the frame table
   function automatic frame_result_type predict_reference(input logic [PAGE_W-1:0] pg);
      int unsigned      n;
      int unsigned      act;
      int unsigned      h;
      int unsigned      slot;
      bit               found;
      bit               swept;
      logic [1:0]       mode;
      frame_result_type r;
      n = cfg_frames;
      if (n < 1) n = 1;
      if (n > FRAME_DEPTH) n = FRAME_DEPTH;
      act  = (filled_count < n) ? filled_count : n;
      h    = (hand_pos < n) ? hand_pos : 0;
      mode = (cfg_policy == POLICY_CLOCK || cfg_policy == POLICY_LRU) ? cfg_policy
                                                                      : POLICY_FIFO;
      slot  = 0;
      found = 1'b0;
      swept = 1'b0;
      r     = '0;
      for (int unsigned k = 0; k < act; k++) begin
         if (!found && resident_page[k] == pg) begin
            slot  = k;
            found = 1'b1;
         end
      end
      if (found) begin
         r.hit = 1'b1;
         use_bit[slot] = 1'b1;
         touch_frame(slot, act, rank_of[slot]);
      end else if (filled_count < n) begin
         // fill the next free frame
         slot = filled_count;
         resident_page[slot] = pg;
         use_bit[slot] = 1'b1;
         touch_frame(slot, act + 1, 255);
         filled_count++;
         hand_pos = (h + 1) % n;
      end else begin
         r.repl = 1'b1;
         if (mode == POLICY_LRU) begin
            // oldest rank wins, lowest index on ties
            for (int unsigned k = 1; k < n; k++) begin
               if (rank_of[k] > rank_of[slot]) slot = k;
            end
         end else if (mode == POLICY_CLOCK) begin
            // sweep, clearing use bits, until a clear one turns up
            slot = h;
            for (int unsigned s = 0; s < 2 * n + 1 && !swept; s++) begin
               if (!use_bit[h]) begin
                  slot  = h;
                  swept = 1'b1;
               end else begin
                  use_bit[h] = 1'b0;
                  h = (h + 1) % n;
               end
            end
            hand_pos = (slot + 1) % n;
         end else begin
            slot = h;
            hand_pos = (h + 1) % n;
         end
         r.evicted = resident_page[slot];
         resident_page[slot] = pg;
         touch_frame(slot, n, rank_of[slot]);
         if (fault_total < FAULT_MAX) fault_total++;
      end
      r.slot   = slot[SLOT_W-1:0];
      r.faults = fault_total[FAULT_W-1:0];
      return r;
   endfunction

   task automatic note_mismatch(input string what, input frame_result_type want,
                                input frame_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("ERROR %s at result %0d: expected hit=%0d repl=%0d slot=%0d ev=%02h fc=%0d",
                  what, results_seen, want.hit, want.repl, want.slot, want.evicted,
                  want.faults);
         $display("      got hit=%0d repl=%0d slot=%0d ev=%02h fc=%0d",
                  got.hit, got.repl, got.slot, got.evicted, got.faults);
      end
   endtask

   // Result checker
   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.hit     = rsp_tuser[0];
         got.repl    = rsp_tuser[1];
         got.slot    = rsp_tdata[2:0];
         got.evicted = rsp_tdata[10:3];
         got.faults  = rsp_tdata[26:11];
         results_seen++;
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected result", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) note_mismatch("field mismatch", want, got);
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off, none while idle_on is low
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_done && results_seen >= HOLD_AT) begin
            rsp_tready = 1'b0;
            for (int unsigned c = 1; c < HOLD_CYCLES; c++) @(negedge clock);
            hold_done = 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Offer one page reference; returns at the edge of its transfer
   task automatic push_page(input logic [PAGE_W-1:0] pg, input bit typed_row,
                            input frame_result_type typed);
      frame_result_type predicted;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = pg;
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = predict_reference(pg);
      pending_results = {pending_results, (typed_row ? typed : predicted)};
      references++;
   endtask

   // Stop offering and wait until every result is back
   task automatic drain_results;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register write, only with the block idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] sel,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = sel;
      csr_data  = value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (sel == CSR_POLICY) cfg_policy = value[1:0];
      else cfg_frames = value;
      reg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Stimulus
   initial begin
      logic [PAGE_W-1:0]     hot_pages [12];
      logic [PAGE_W-1:0]     pg;
      logic [PAGE_W-1:0]     last_pg;
      logic [CSR_DATA_W-1:0] pol_value;
      logic [CSR_DATA_W-1:0] frames_value;
      int unsigned           hot_size;
      int unsigned           phase_len;
      int unsigned           random_refs;
      int unsigned           phase;
      int unsigned           directed_refs;

      for (int unsigned k = 0; k < FRAME_DEPTH; k++) begin
         resident_page[k] = '0;
         use_bit[k]       = 1'b0;
         rank_of[k]       = 0;
      end
      filled_count = 0;
      hand_pos     = 0;
      fault_total  = 0;
      cfg_policy   = POLICY_FIFO;
      cfg_frames   = FRAMES_RESET;
      idle_on      = 1'b1;
      random_refs  = 0;
      phase        = 0;

      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Directed table
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            drain_results();
            write_reg(directed_plan[i].reg_sel, directed_plan[i].value);
         end else begin
            push_page(directed_plan[i].page, directed_plan[i].kind == ROW_CHECKED,
                      directed_plan[i].want);
         end
      end
      directed_refs = references;

      // Random phases: a fresh setting, then references drawn mostly from a hot set
      while (random_refs < RANDOM_REFS) begin
         drain_results();
         pol_value = CSR_DATA_W'($urandom_range(0, 15));
         pol_value[1:0] = phase[1:0];
         frames_value = (phase < SWEEP_LEN) ? frame_sweep[phase]
                                            : CSR_DATA_W'($urandom_range(0, 15));
         write_reg(CSR_POLICY, pol_value);
         write_reg(CSR_FRAMES, frames_value);
         idle_on  = (phase % 4 != 3);
         hot_size = $urandom_range(2, 12);
         for (int unsigned k = 0; k < hot_size; k++) begin
            hot_pages[k] = PAGE_W'($urandom_range(0, 255));
         end
         phase_len = $urandom_range(40, 100);
         for (int unsigned j = 0; j < phase_len; j++) begin
            if ($urandom_range(0, 99) < 85) pg = hot_pages[$urandom_range(0, hot_size - 1)];
            else pg = PAGE_W'($urandom_range(0, 255));
            push_page(pg, 1'b0, '0);
            random_refs++;
         end
         phase++;
      end

      // Last part, no idling: one frame, FIFO, every reference misses and replaces
      drain_results();
      idle_on = 1'b0;
      write_reg(CSR_POLICY, {2'b00, POLICY_FIFO});
      write_reg(CSR_FRAMES, 4'd1);
      last_pg = resident_page[0];
      for (int unsigned j = 0; j < LAST_REFS; j++) begin
         pg = PAGE_W'($urandom_range(0, 255));
         if (pg == last_pg) pg = ~pg;
         push_page(pg, 1'b0, '0);
         last_pg = pg;
      end

      // Wrap up
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_results.size() != 0) begin
         mismatches += pending_results.size();
         $display("ERROR %0d results never arrived", pending_results.size());
      end
      $display("Run: %0d references (%0d from the table) under %0d register writes, %0d phases",
               references, directed_refs, reg_writes, phase);
      $display("Run: all policies, frame counts 0 to 15, a long receiver hold, fault count %0d",
               fault_total);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
